[rtl/core/lsd_pkg.sv]
// Shared types and constants of the lagged squared displacement block.
package lsd_pkg;

    localparam int DIMS     = 3;
    localparam int COORD_W  = 16;
    localparam int POS_W    = DIMS * COORD_W;
    localparam int PART_W   = 10;
    localparam int LAG_W    = 4;
    localparam int LTIME_W  = 20;
    localparam int SQ_W     = 34;
    localparam int SQ1_W    = 33;
    localparam int STEP_W   = 5;
    localparam int SLOT_W   = 6;
    localparam int FRAMES_W = 5;
    localparam int PCNT_W   = 11;
    localparam int HIST_W   = 5;
    localparam int TSTEP_W  = 16;
    localparam int CFG_IDX_W = 2;

    // Depth of the result queue in front of the output port.
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_FRAMES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = 2'd2;

    localparam logic [FRAMES_W-1:0] FRAMES_SAT = 5'd31;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_slot;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_slot;
        logic [STEP_W-1:0] step;
        logic              last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_beat;
    } t_dp_status;

    typedef struct packed {
        logic [PART_W-1:0]  particle_out;
        logic [LAG_W-1:0]   lag;
        logic [LTIME_W-1:0] lag_time;
        logic [SQ_W-1:0]    squared_displacement;
        logic               last;
    } t_result;

endpackage

[rtl/core/lsd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lsd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/lsd_ctrl.sv]
// Controller: frame bookkeeping, lag sequencing and output credit tracking.
module lsd_ctrl
    import lsd_pkg::*;
#(
    parameter int MAX_PARTICLES = 1024,
    parameter int MAX_HISTORY   = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_first_of_frame,
    input  logic [PART_W-1:0] i_particle,
    input  logic [PCNT_W-1:0] i_particle_count,
    input  logic [HIST_W-1:0] i_history_frames,
    output t_dp_cmd           o_cmd,
    input  t_dp_status        i_status
);

    localparam int SW = $clog2(MAX_HISTORY);
    localparam logic [HIST_W-1:0] H_CAP =
        (MAX_HISTORY > 31) ? 5'd31 : HIST_W'(MAX_HISTORY);
    localparam logic [SW-1:0] SLOT_RST =
        SW'((MAX_HISTORY - 1 > 15) ? 15 : MAX_HISTORY - 1);

    typedef enum logic {
        S_IDLE,
        S_ISSUE
    } t_state;

    t_state              r_state, n_state;
    logic [SW-1:0]       r_slot, n_slot;
    logic [FRAMES_W-1:0] r_frames, n_frames;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [STEP_W-1:0]   r_lags, n_lags;
    logic [QCNT_W-1:0]   r_credit, n_credit;

    logic [HIST_W-1:0]   w_eff_hist;
    logic [SLOT_W:0]     w_slot_inc;
    logic [SW-1:0]       w_slot_acc;
    logic [FRAMES_W-1:0] w_frames_acc;
    logic [FRAMES_W-1:0] w_lags_acc;
    logic                w_in_range;
    logic                w_accept;
    logic                w_issue;
    logic [SLOT_W:0]     w_rd_diff;
    logic [SW-1:0]       w_rd_slot;

    always_comb begin
        if (i_history_frames < 5'd2) begin
            w_eff_hist = 5'd2;
        end else if (i_history_frames > H_CAP) begin
            w_eff_hist = H_CAP;
        end else begin
            w_eff_hist = i_history_frames;
        end
    end

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && (r_state == S_IDLE);
    assign w_issue  = (r_state == S_ISSUE) && (r_credit != '0);

    // A marked item opens a new frame in the next ring slot.
    assign w_slot_inc = (SLOT_W+1)'(r_slot) + 7'd1;
    always_comb begin
        if (!i_first_of_frame) begin
            w_slot_acc = r_slot;
        end else if (w_slot_inc >= (SLOT_W+1)'(w_eff_hist)) begin
            w_slot_acc = '0;
        end else begin
            w_slot_acc = SW'(w_slot_inc);
        end
    end

    assign w_frames_acc = (i_first_of_frame && (r_frames != FRAMES_SAT)) ?
                          r_frames + 5'd1 : r_frames;

    // The particle index must lie below the clamped particle count.
    assign w_in_range = (({1'b0, i_particle} < i_particle_count) ||
                         (i_particle == '0)) &&
                        (32'(i_particle) < MAX_PARTICLES);

    assign w_lags_acc = ((w_frames_acc - 5'd1) < (w_eff_hist - 5'd1)) ?
                        (w_frames_acc - 5'd1) : (w_eff_hist - 5'd1);

    // Slot of the frame that lies r_step frames back, wrapped in the ring.
    assign w_rd_diff = (SLOT_W+1)'(r_slot) - (SLOT_W+1)'(r_step);
    assign w_rd_slot = w_rd_diff[SLOT_W] ?
                       SW'(w_rd_diff + (SLOT_W+1)'(w_eff_hist)) : SW'(w_rd_diff);

    always_comb begin
        n_state  = r_state;
        n_slot   = r_slot;
        n_frames = r_frames;
        n_step   = r_step;
        n_lags   = r_lags;
        n_credit = r_credit;
        if (w_issue && !i_status.out_beat) begin
            n_credit = r_credit - 3'd1;
        end else if (!w_issue && i_status.out_beat) begin
            n_credit = r_credit + 3'd1;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_slot   = w_slot_acc;
                    n_frames = w_frames_acc;
                    n_step   = 5'd1;
                    n_lags   = w_lags_acc;
                    if (w_in_range && (w_frames_acc >= 5'd2)) begin
                        n_state = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                if (w_issue) begin
                    if (r_step == r_lags) begin
                        n_state = S_IDLE;
                    end else begin
                        n_step = r_step + 5'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_slot   <= SLOT_RST;
            r_frames <= '0;
            r_step   <= 5'd1;
            r_lags   <= '0;
            r_credit <= QCNT_W'(QDEPTH);
        end else begin
            r_state  <= n_state;
            r_slot   <= n_slot;
            r_frames <= n_frames;
            r_step   <= n_step;
            r_lags   <= n_lags;
            r_credit <= n_credit;
        end
    end

    always_comb begin
        o_cmd.load    = w_accept;
        o_cmd.wr_en   = w_accept && w_in_range;
        o_cmd.wr_slot = SLOT_W'(w_slot_acc);
        o_cmd.rd_en   = w_issue;
        o_cmd.rd_slot = SLOT_W'(w_rd_slot);
        o_cmd.step    = r_step;
        o_cmd.last    = (r_step == r_lags);
    end

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= QCNT_W'(QDEPTH))
        else $error("credit count above queue depth");

    a_issue_needs_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |-> (r_credit != '0))
        else $error("read issued without queue space");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && (r_step == r_lags)) |=> (r_state == S_IDLE))
        else $error("sequencer did not stop after the last lag");

endmodule

[rtl/core/lsd_dp.sv]
// Datapath: position store, squared difference pipeline and result queue.
module lsd_dp
    import lsd_pkg::*;
#(
    parameter int MAX_PARTICLES = 1024,
    parameter int MAX_HISTORY   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    input  logic [PART_W-1:0]  i_particle,
    input  logic [COORD_W-1:0] i_pos_x,
    input  logic [COORD_W-1:0] i_pos_y,
    input  logic [COORD_W-1:0] i_pos_z,
    input  logic [TSTEP_W-1:0] i_time_step,
    output logic               o_valid,
    input  logic               i_stall,
    output t_result            o_result
);

    localparam int SW   = $clog2(MAX_HISTORY);
    localparam int PW_R = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int PW   = (PW_R > PART_W) ? PART_W : PW_R;
    localparam int AW   = SW + PW;
    localparam int DEPTH = 1 << AW;

    // Item held for the duration of its lag sequence.
    logic [PART_W-1:0] r_part;
    logic [POS_W-1:0]  r_pos;

    // Stage 1: read data arrives from the store.
    logic              r1_v;
    logic [PART_W-1:0] r1_part;
    logic [STEP_W-1:0] r1_step;
    logic              r1_last;
    logic [POS_W-1:0]  r1_pos;
    logic [POS_W-1:0]  w_rdata;

    // Stage 2: squared coordinate differences.
    logic              r2_v;
    logic [PART_W-1:0] r2_part;
    logic [STEP_W-1:0] r2_step;
    logic              r2_last;
    logic [SQ1_W-1:0]  r2_sq [DIMS];
    logic [LTIME_W-1:0] r2_ltime;

    logic signed [COORD_W:0] w_diff [DIMS];
    logic signed [SQ_W-1:0]  w_sq   [DIMS];
    logic [LTIME_W:0]        w_ltime;

    // Result queue.
    t_result           r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push, w_pop;
    t_result           w_res;

    lsd_ram #(
        .WIDTH (POS_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr ({SW'(i_cmd.wr_slot), i_particle[PW-1:0]}),
        .i_wdata ({i_pos_z, i_pos_y, i_pos_x}),
        .i_re    (i_cmd.rd_en),
        .i_raddr ({SW'(i_cmd.rd_slot), r_part[PW-1:0]}),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_part <= i_particle;
            r_pos  <= {i_pos_z, i_pos_y, i_pos_x};
        end
        if (i_cmd.rd_en) begin
            r1_part <= r_part;
            r1_step <= i_cmd.step;
            r1_last <= i_cmd.last;
            r1_pos  <= r_pos;
        end
        if (r1_v) begin
            r2_part  <= r1_part;
            r2_step  <= r1_step;
            r2_last  <= r1_last;
            r2_ltime <= w_ltime[LTIME_W-1:0];
            for (int k = 0; k < DIMS; k++) begin
                r2_sq[k] <= w_sq[k][SQ1_W-1:0];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < DIMS; k++) begin
            w_diff[k] = (COORD_W+1)'(signed'(r1_pos[COORD_W*k +: COORD_W])) -
                        (COORD_W+1)'(signed'(w_rdata[COORD_W*k +: COORD_W]));
            w_sq[k]   = SQ_W'(w_diff[k]) * SQ_W'(w_diff[k]);
        end
    end

    assign w_ltime = (LTIME_W+1)'(r1_step) * (LTIME_W+1)'(i_time_step);

    always_comb begin
        w_res.particle_out         = r2_part;
        w_res.lag                  = r2_step[LAG_W-1:0];
        w_res.lag_time             = r2_ltime;
        w_res.squared_displacement = SQ_W'(r2_sq[0]) + SQ_W'(r2_sq[1]) +
                                     SQ_W'(r2_sq[2]);
        w_res.last                 = r2_last;
    end

    assign w_push = r2_v;
    assign w_pop  = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r1_v <= i_cmd.rd_en;
            r2_v <= r1_v;
            if (w_push) begin
                r_wptr <= r_wptr + 2'd1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 2'd1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 3'd1;
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - 3'd1;
            end
        end
    end

    assign o_valid           = (r_cnt != '0);
    assign o_result          = r_q[r_rptr];
    assign o_status.out_beat = w_pop;

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> ((r_cnt < QCNT_W'(QDEPTH)) || w_pop))
        else $error("result queue overflow");

    a_pipe_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |=> ##1 r2_v)
        else $error("issued read did not reach the square stage");

endmodule

[rtl/core/lagged_squared_displacement_top.sv]
// Top level of the lagged squared displacement block: registers and wiring.
//
// Input channel: one beat per particle position (i_valid / o_stall), with
// i_first_of_frame marking the first position of a new frame. Output
// channel: one beat per lag result (o_valid / i_stall), lags in increasing
// order, o_last set on the largest lag of an item.
// An item whose particle is in range and that has L earlier frames to
// compare against is first accepted and its position stored, then the
// position store is read once per lag; that single read port sets the
// rate. Items that yield no results leave the block free for the next
// item. Each read passes through the read data register, the squared
// difference register and the result queue before it reaches the output.
// Results pass through a four-beat queue; when the receiver stalls, reads
// pause once all queue space is claimed and resume as beats are taken.
// Reset (synchronous, active low) empties the queue and the pipeline,
// clears the frame count, points the ring at its last slot so the first
// frame lands in slot 0, and loads the register defaults. The position
// store is not cleared; it needs no clearing pass.
// Configuration writes take effect at once and are meant for idle periods.
module lagged_squared_displacement_top
    import lsd_pkg::*;
#(
    parameter int MAX_PARTICLES = 1024,
    parameter int MAX_HISTORY   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_first_of_frame,
    input  logic [PART_W-1:0]    i_particle,
    input  logic signed [COORD_W-1:0] i_pos_x,
    input  logic signed [COORD_W-1:0] i_pos_y,
    input  logic signed [COORD_W-1:0] i_pos_z,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [PART_W-1:0]    o_particle_out,
    output logic [LAG_W-1:0]     o_lag,
    output logic [LTIME_W-1:0]   o_lag_time,
    output logic [SQ_W-1:0]      o_squared_displacement,
    output logic                 o_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TSTEP_W-1:0]   i_cfg_data
);

    logic [PCNT_W-1:0]  r_particle_count;
    logic [HIST_W-1:0]  r_history_frames;
    logic [TSTEP_W-1:0] r_time_step;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    t_result    w_result;

    // Configuration registers; an index outside the register list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_particle_count <= 11'd1;
            r_history_frames <= 5'd16;
            r_time_step      <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PARTICLE_COUNT: r_particle_count <= i_cfg_data[PCNT_W-1:0];
                CFG_HISTORY_FRAMES: r_history_frames <= i_cfg_data[HIST_W-1:0];
                CFG_TIME_STEP:      r_time_step      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lsd_ctrl #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .MAX_HISTORY   (MAX_HISTORY)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_first_of_frame (i_first_of_frame),
        .i_particle       (i_particle),
        .i_particle_count (r_particle_count),
        .i_history_frames (r_history_frames),
        .o_cmd            (w_cmd),
        .i_status         (w_status)
    );

    lsd_dp #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .MAX_HISTORY   (MAX_HISTORY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_particle  (i_particle),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_time_step (r_time_step),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (w_result)
    );

    assign o_particle_out         = w_result.particle_out;
    assign o_lag                  = w_result.lag;
    assign o_lag_time             = w_result.lag_time;
    assign o_squared_displacement = w_result.squared_displacement;
    assign o_last                 = w_result.last;

endmodule

[tb/lagged_squared_displacement_top_test.sv]
// Self-checking testbench of the lagged squared displacement block.
`timescale 1ns / 1ps

module lagged_squared_displacement_top_test
    import lsd_pkg::*;
();

    localparam int RING_SLOTS    = 16;
    localparam int PARTICLE_SPAN = 1024;
    // Particles 0..7 and the top index 1023 are the ones whose positions are
    // tracked through every slot of the ring.
    localparam int TRACKED_COUNT = 9;
    localparam int RANDOM_ITEMS  = 500;
    // The block reads the store once per lag and each read passes through its
    // pipeline registers, so this many quiet cycles after the last result
    // covers any item still in flight that yields no results.
    localparam int SETTLE_CYCLES = 16;
    localparam int REPORT_LIMIT  = 10;
    localparam longint RUN_LIMIT_NS = 4_000_000;

    localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic                        i_first_of_frame = 1'b0;
    logic [PART_W-1:0]           i_particle = '0;
    logic signed [COORD_W-1:0]   i_pos_x = '0;
    logic signed [COORD_W-1:0]   i_pos_y = '0;
    logic signed [COORD_W-1:0]   i_pos_z = '0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic [PART_W-1:0]           o_particle_out;
    logic [LAG_W-1:0]            o_lag;
    logic [LTIME_W-1:0]          o_lag_time;
    logic [SQ_W-1:0]             o_squared_displacement;
    logic                        o_last;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [TSTEP_W-1:0]          i_cfg_data = '0;

    // Predicted state of the block: the position ring, the frame pointer,
    // the frame count and the register values as written.
    logic signed [COORD_W-1:0] ring_x [RING_SLOTS][PARTICLE_SPAN];
    logic signed [COORD_W-1:0] ring_y [RING_SLOTS][PARTICLE_SPAN];
    logic signed [COORD_W-1:0] ring_z [RING_SLOTS][PARTICLE_SPAN];
    bit                        ring_written [RING_SLOTS][PARTICLE_SPAN];
    int unsigned               ring_slot;
    int unsigned               frames_count;
    int unsigned               cfg_pcount;
    int unsigned               cfg_hist;
    int unsigned               cfg_tstep;

    // Displacement results that the block still owes, oldest first.
    t_result                   expected_disp_q [$];

    int unsigned               error_count = 0;
    int unsigned               rx_wait = 0;
    // When low, neither side inserts idle cycles or stalls.
    bit                        idle_on = 1'b1;

    lagged_squared_displacement_top DUT (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_first_of_frame       (i_first_of_frame),
        .i_particle             (i_particle),
        .i_pos_x                (i_pos_x),
        .i_pos_y                (i_pos_y),
        .i_pos_z                (i_pos_z),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_particle_out         (o_particle_out),
        .o_lag                  (o_lag),
        .o_lag_time             (o_lag_time),
        .o_squared_displacement (o_squared_displacement),
        .o_last                 (o_last),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Number of idle or stall cycles before the next beat on either side.
    function automatic int unsigned draw_wait();
        return idle_on ? $urandom_range(0, 4) : 0;
    endfunction

    function automatic int unsigned tracked_particle(input int k);
        return (k < TRACKED_COUNT - 1) ? k : PARTICLE_SPAN - 1;
    endfunction

    // Out-of-range register values are clamped by the block, not rejected.
    function automatic int unsigned particles_in_use();
        if (cfg_pcount < 1) return 1;
        if (cfg_pcount > PARTICLE_SPAN) return PARTICLE_SPAN;
        return cfg_pcount;
    endfunction

    function automatic int unsigned history_in_use();
        if (cfg_hist < 2) return 2;
        if (cfg_hist > RING_SLOTS) return RING_SLOTS;
        return cfg_hist;
    endfunction

    function automatic int unsigned next_slot(input int unsigned slot, input int unsigned hf);
        return (slot + 1 >= hf) ? 0 : slot + 1;
    endfunction

    // Slot that holds the position from the given number of frames back.
    // The pointer may sit above a freshly lowered ring size; it then counts
    // down from where it is and only wraps below zero.
    function automatic int unsigned slot_back(input int unsigned slot, input int unsigned lag,
                                              input int unsigned hf);
        int s;
        s = int'(slot) - int'(lag);
        if (s < 0) s += int'(hf);
        return s;
    endfunction

    function automatic int unsigned lag_count(input int unsigned frames, input int unsigned hf);
        if (frames < 2) return 0;
        return (frames - 1 > hf - 1) ? hf - 1 : frames - 1;
    endfunction

    function automatic logic signed [COORD_W-1:0] draw_coord();
        case ($urandom_range(0, 3))
            0, 1: return COORD_W'($urandom);
            2: begin
                case ($urandom_range(0, 3))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return 16'sd0;
                    default: return -16'sd1;
                endcase
            end
            default: return COORD_W'($urandom_range(0, 15)) - 16'sd8;
        endcase
    endfunction

    // A store entry that was never written has no defined content, so an
    // item that would compare against one is never sent.
    function automatic bit positions_readable(input bit first, input int unsigned p);
        int unsigned hf;
        int unsigned slot;
        int unsigned frames;
        int unsigned lag;
        hf = history_in_use();
        slot = ring_slot;
        frames = frames_count;
        if (first) begin
            slot = next_slot(slot, hf);
            if (frames < FRAMES_SAT) frames++;
        end
        if (p >= particles_in_use()) return 1'b1;
        for (lag = 1; lag <= lag_count(frames, hf); lag++) begin
            if (!ring_written[slot_back(slot, lag, hf)][p]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Updates the predicted state with one accepted position and queues the
    // displacement it yields for every stored earlier frame.
    function automatic void predict_position(input bit first, input int unsigned p,
                                             input logic signed [COORD_W-1:0] px,
                                             input logic signed [COORD_W-1:0] py,
                                             input logic signed [COORD_W-1:0] pz);
        int unsigned hf;
        int unsigned lags;
        int unsigned lag;
        int unsigned s;
        longint      dx;
        longint      dy;
        longint      dz;
        longint      sum;
        t_result     r;
        hf = history_in_use();
        if (first) begin
            ring_slot = next_slot(ring_slot, hf);
            if (frames_count < FRAMES_SAT) frames_count++;
        end
        if (p >= particles_in_use()) return;
        ring_x[ring_slot][p] = px;
        ring_y[ring_slot][p] = py;
        ring_z[ring_slot][p] = pz;
        ring_written[ring_slot][p] = 1'b1;
        lags = lag_count(frames_count, hf);
        for (lag = 1; lag <= lags; lag++) begin
            s = slot_back(ring_slot, lag, hf);
            dx = longint'(px) - longint'(ring_x[s][p]);
            dy = longint'(py) - longint'(ring_y[s][p]);
            dz = longint'(pz) - longint'(ring_z[s][p]);
            sum = dx * dx + dy * dy + dz * dz;
            r.particle_out = p[PART_W-1:0];
            r.lag = LAG_W'(lag);
            r.lag_time = LTIME_W'(lag * cfg_tstep);
            r.squared_displacement = SQ_W'(sum);
            r.last = (lag == lags);
            expected_disp_q.push_back(r);
        end
    endfunction

    // Sends one position beat and waits until the block takes it. Valid is
    // left high on return so that a following beat can go back to back.
    task automatic send_position(input bit first, input int unsigned p,
                                 input logic signed [COORD_W-1:0] px,
                                 input logic signed [COORD_W-1:0] py,
                                 input logic signed [COORD_W-1:0] pz);
        int unsigned gap;
        if (!positions_readable(first, p)) return;
        gap = draw_wait();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_first_of_frame <= first;
        i_particle <= p[PART_W-1:0];
        i_pos_x <= px;
        i_pos_y <= py;
        i_pos_z <= pz;
        do @(posedge i_clk); while (o_stall);
        predict_position(first, p, px, py, pz);
    endtask

    task automatic send_random_position(input bit first, input int unsigned p);
        send_position(first, p, draw_coord(), draw_coord(), draw_coord());
    endtask

    // Stops the input side and waits until every owed result has been taken
    // and the pipeline has had time to finish items that yield none.
    task automatic settle_block();
        i_valid <= 1'b0;
        while (expected_disp_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes happen only while the block is idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [TSTEP_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (index)
            CFG_PARTICLE_COUNT: cfg_pcount = 32'(data[PCNT_W-1:0]);
            CFG_HISTORY_FRAMES: cfg_hist = 32'(data[HIST_W-1:0]);
            CFG_TIME_STEP:      cfg_tstep = 32'(data);
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Positions that arrive before any frame marker land in the last slot
    // and yield nothing; a particle beyond the default count of one is dropped.
    task automatic test_positions_before_frame();
        send_position(1'b0, 0, COORD_MIN, COORD_MIN, COORD_MIN);
        send_position(1'b0, 1, 16'sd1, 16'sd2, 16'sd3);
    endtask

    // The first frame has nothing to compare against. It is opened under the
    // default particle count, then widened to the full range so that every
    // tracked particle, the top index among them, gets a first position.
    task automatic test_first_frame();
        int k;
        send_position(1'b1, 0, COORD_MIN, COORD_MIN, COORD_MIN);
        settle_block();
        write_register(CFG_PARTICLE_COUNT, 16'(PARTICLE_SPAN));
        for (k = 1; k < TRACKED_COUNT; k++) send_random_position(1'b0, tracked_particle(k));
    endtask

    // Opposite corners of the coordinate range give the largest possible
    // squared displacement at lag one, with the default time step of one.
    task automatic test_extreme_displacement();
        int k;
        send_position(1'b1, 0, COORD_MAX, COORD_MAX, COORD_MAX);
        send_position(1'b0, PARTICLE_SPAN - 1, COORD_MIN, COORD_MAX, COORD_MIN);
        for (k = 1; k < TRACKED_COUNT - 1; k++) send_random_position(1'b0, tracked_particle(k));
    endtask

    // Complete frames until every slot of the default sixteen-frame ring
    // holds every tracked particle and the lag count reaches its maximum.
    task automatic test_ring_fill();
        int frame;
        int k;
        for (frame = 3; frame <= RING_SLOTS + 1; frame++) begin
            for (k = 0; k < TRACKED_COUNT; k++) send_random_position(k == 0, tracked_particle(k));
        end
    endtask

    // Register values outside their ranges, and bits above each register's
    // width, must clamp or be ignored. Each write waits for an idle block.
    task automatic test_register_limits();
        settle_block();
        write_register(CFG_PARTICLE_COUNT, 16'h0800);
        send_random_position(1'b1, 0);
        send_random_position(1'b0, 1);
        settle_block();
        write_register(CFG_PARTICLE_COUNT, 16'hFFFF);
        send_random_position(1'b0, PARTICLE_SPAN - 1);
        settle_block();
        write_register(CFG_HISTORY_FRAMES, 16'hFFE1);
        send_random_position(1'b1, 3);
        send_random_position(1'b0, PARTICLE_SPAN - 1);
        settle_block();
        write_register(CFG_HISTORY_FRAMES, 16'h0000);
        send_random_position(1'b1, 2);
        settle_block();
        write_register(CFG_HISTORY_FRAMES, 16'h001F);
        write_register(CFG_TIME_STEP, 16'h0000);
        send_random_position(1'b1, 4);
        settle_block();
        write_register(CFG_TIME_STEP, 16'hFFFF);
        send_random_position(1'b0, 5);
        send_position(1'b1, 6, COORD_MIN, COORD_MAX, 16'sd0);
    endtask

    // A marked position for a particle past the count still opens a frame,
    // even though its own position is thrown away.
    task automatic test_out_of_range_marker();
        settle_block();
        write_register(CFG_PARTICLE_COUNT, 16'd4);
        send_random_position(1'b1, 9);
        send_random_position(1'b0, 0);
        send_random_position(1'b0, 3);
        send_random_position(1'b1, PARTICLE_SPAN - 1);
        send_random_position(1'b0, 2);
    endtask

    // One frame with the in-range tracked particles in shuffled order. Some
    // frames lose their marker, some particles are skipped or repeated, and
    // out-of-range positions are mixed in. Only in-range beats are counted.
    task automatic send_random_frame(inout int unsigned counted);
        int unsigned members [TRACKED_COUNT];
        int unsigned pc_eff;
        int unsigned tmp;
        int          n;
        int          i;
        int          j;
        int          k;
        bit          marked;
        pc_eff = particles_in_use();
        n = 0;
        for (k = 0; k < TRACKED_COUNT; k++) begin
            if (tracked_particle(k) < pc_eff) begin
                members[n] = tracked_particle(k);
                n++;
            end
        end
        for (i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = members[i];
            members[i] = members[j];
            members[j] = tmp;
        end
        marked = ($urandom_range(0, 15) == 0);
        for (i = 0; i < n; i++) begin
            if (pc_eff < PARTICLE_SPAN && $urandom_range(0, 9) == 0) begin
                send_random_position(!marked && $urandom_range(0, 1),
                                     $urandom_range(pc_eff, PARTICLE_SPAN - 1));
                marked = marked || i_first_of_frame;
            end
            if ($urandom_range(0, 11) != 0) begin
                send_random_position(!marked, members[i]);
                marked = 1'b1;
                counted++;
                if ($urandom_range(0, 15) == 0) begin
                    send_random_position(1'b0, members[i]);
                    counted++;
                end
            end
        end
    endtask

    // Phases of random frames under random register settings. Each phase
    // starts from an idle block, so the sender stops until every result of
    // the previous phase has been taken.
    task automatic test_random_frames();
        int unsigned counted;
        int unsigned frames;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            settle_block();
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 6))
                    0: write_register(CFG_PARTICLE_COUNT, {5'($urandom), 11'd0});
                    1: write_register(CFG_PARTICLE_COUNT, {5'($urandom), 11'd1});
                    2: write_register(CFG_PARTICLE_COUNT, 16'd8);
                    3: write_register(CFG_PARTICLE_COUNT, 16'($urandom_range(9, 1023)));
                    4: write_register(CFG_PARTICLE_COUNT, 16'd1024);
                    5: write_register(CFG_PARTICLE_COUNT, {5'($urandom), 11'd2047});
                    default: write_register(CFG_PARTICLE_COUNT, 16'($urandom_range(2, 7)));
                endcase
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 4))
                    0: write_register(CFG_HISTORY_FRAMES,
                                      {11'($urandom), 5'($urandom_range(0, 1))});
                    1: write_register(CFG_HISTORY_FRAMES, 16'd2);
                    2: write_register(CFG_HISTORY_FRAMES, 16'd16);
                    3: write_register(CFG_HISTORY_FRAMES,
                                      {11'($urandom), 5'($urandom_range(17, 31))});
                    default: write_register(CFG_HISTORY_FRAMES, 16'($urandom_range(3, 15)));
                endcase
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 3))
                    0: write_register(CFG_TIME_STEP, 16'd0);
                    1: write_register(CFG_TIME_STEP, 16'hFFFF);
                    2: write_register(CFG_TIME_STEP, 16'd1);
                    default: write_register(CFG_TIME_STEP, 16'($urandom));
                endcase
            end
            idle_on = ($urandom_range(0, 3) != 0);
            frames = $urandom_range(2, 8);
            repeat (frames) send_random_frame(counted);
        end
        idle_on = 1'b1;
    endtask

    // Result side: every accepted beat is compared with the oldest owed
    // result. The stall pattern counts down only while a beat is offered.
    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (o_valid && !i_stall) begin
            seen = {o_particle_out, o_lag, o_lag_time, o_squared_displacement, o_last};
            if (expected_disp_q.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: result beat with none owed: particle %0d lag %0d",
                             $realtime, seen.particle_out, seen.lag);
            end else begin
                want = expected_disp_q.pop_front();
                if (seen !== want) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display({"%0t: mismatch, expected particle %0d lag %0d",
                                  " lag_time %0d sq %0d last %0d"},
                                 $realtime, want.particle_out, want.lag, want.lag_time,
                                 want.squared_displacement, want.last);
                        $display({"%0t:           got particle %0d lag %0d",
                                  " lag_time %0d sq %0d last %0d"},
                                 $realtime, seen.particle_out, seen.lag, seen.lag_time,
                                 seen.squared_displacement, seen.last);
                    end
                end
            end
            rx_wait = draw_wait();
        end else if (o_valid && rx_wait != 0) begin
            rx_wait--;
        end
        i_stall <= (rx_wait != 0);
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        // The predicted state starts from the block's reset values: empty
        // ring, pointer on the last slot, no frames, default registers.
        foreach (ring_written[s, p]) ring_written[s][p] = 1'b0;
        ring_slot = RING_SLOTS - 1;
        frames_count = 0;
        cfg_pcount = 1;
        cfg_hist = RING_SLOTS;
        cfg_tstep = 1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_positions_before_frame();
        test_first_frame();
        test_extreme_displacement();
        test_ring_fill();
        test_register_limits();
        test_out_of_range_marker();
        test_random_frames();
        settle_block();
        if (error_count == 0 && expected_disp_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[lagged_squared_displacement_top.f]
rtl/core/lsd_pkg.sv
rtl/core/lsd_ram.sv
rtl/core/lsd_ctrl.sv
rtl/core/lsd_dp.sv
rtl/core/lagged_squared_displacement_top.sv
tb/lagged_squared_displacement_top_test.sv
